>>> hw/rtl/smpd_pkg.sv
`timescale 1ns / 1ps

package smpd_pkg;

  // Protocol selected by the mode register.
  typedef enum logic {
    MODE_MOUSE_SYSTEMS = 1'b0,
    MODE_MICROSOFT     = 1'b1
  } protocol_mode_e;

  // Packet phase codes. Mouse Systems uses all four data phases; Microsoft
  // uses only the first X and first Y phases.
  localparam logic [2:0] PH_WAIT_SYNC = 3'd0;
  localparam logic [2:0] PH_X_FIRST   = 3'd1;
  localparam logic [2:0] PH_Y_FIRST   = 3'd2;
  localparam logic [2:0] PH_X_SECOND  = 3'd3;
  localparam logic [2:0] PH_Y_SECOND  = 3'd4;

  localparam logic [7:0] HDR_BASE     = 8'hf8;
  localparam logic [7:0] MS_SYNC_MASK = 8'hf8;
  localparam logic [7:0] MS_SYNC_VAL  = 8'h80;
  localparam logic [7:0] MS_SYNC_BIT  = 8'h40;
  localparam logic [7:0] HIGH_TWO     = 8'hc0;
  localparam logic [7:0] LOW_SIX      = 8'h3f;

  typedef struct packed {
    logic [7:0]        header;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
  } packet_t;

endpackage

>>> hw/rtl/smpd_in_reg.sv
`timescale 1ns / 1ps

module smpd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // The stage can take a new byte when it is empty or drains this cycle.
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

>>> hw/rtl/smpd_decode.sv
`timescale 1ns / 1ps

module smpd_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             advance_i,
  input  logic [7:0]       byte_i,
  output logic             emit_o,
  output smpd_pkg::packet_t packet_o
);

  import smpd_pkg::*;

  protocol_mode_e mode_q;
  logic [2:0]     phase_q, phase_d;
  logic [7:0]     header_q, header_d;
  logic [7:0]     x_q, x_d;
  logic [7:0]     y_high_q, y_high_d;
  logic           emit;
  logic [7:0]     y_out;

  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    x_d      = x_q;
    y_high_d = y_high_q;
    emit     = 1'b0;
    y_out    = 8'd0 - byte_i;
    if (mode_q == MODE_MOUSE_SYSTEMS) begin
      unique case (phase_q)
        PH_X_FIRST, PH_X_SECOND: begin
          x_d     = byte_i;
          phase_d = phase_q + 3'd1;
        end
        PH_Y_FIRST, PH_Y_SECOND: begin
          emit    = 1'b1;
          phase_d = phase_q + 3'd1;
        end
        default: begin
          if ((byte_i & MS_SYNC_MASK) == MS_SYNC_VAL) begin
            // Button bits are active low: bit 2 is left, bit 0 is right.
            header_d = HDR_BASE | {6'd0, !byte_i[2], !byte_i[0]};
            phase_d  = PH_X_FIRST;
          end
        end
      endcase
    end else begin
      unique case (phase_q)
        PH_X_FIRST: begin
          x_d     = (x_q & HIGH_TWO) | (byte_i & LOW_SIX);
          phase_d = PH_Y_FIRST;
        end
        PH_Y_FIRST: begin
          emit    = 1'b1;
          y_out   = (y_high_q & HIGH_TWO) | (byte_i & LOW_SIX);
          phase_d = PH_WAIT_SYNC;
        end
        default: begin
          if ((byte_i & MS_SYNC_BIT) != 8'd0) begin
            header_d = HDR_BASE | {6'd0, byte_i[5:4]};
            x_d      = {byte_i[1:0], 6'd0};
            y_high_d = {byte_i[3:2], 6'd0};
            phase_d  = PH_X_FIRST;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_MOUSE_SYSTEMS;
      phase_q  <= PH_WAIT_SYNC;
      header_q <= 8'd0;
      x_q      <= 8'd0;
      y_high_q <= 8'd0;
    end else if (cfg_we_i) begin
      // A mode write restarts sync search; held fields are kept.
      mode_q  <= protocol_mode_e'(cfg_wdata_i);
      phase_q <= PH_WAIT_SYNC;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      header_q <= header_d;
      x_q      <= x_d;
      y_high_q <= y_high_d;
    end
  end

  assign emit_o           = emit;
  assign packet_o.header  = header_q;
  assign packet_o.delta_x = $signed(x_q);
  assign packet_o.delta_y = $signed(y_out);

endmodule

>>> hw/rtl/smpd_out_reg.sv
`timescale 1ns / 1ps

module smpd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  input  logic              emit_i,
  input  smpd_pkg::packet_t packet_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output smpd_pkg::packet_t packet_o
);

  import smpd_pkg::*;

  logic    valid_q, valid_d;
  packet_t packet_q;

  // A byte leaves the input stage whenever the result register is free or
  // is being emptied, whether or not the byte completes a packet.
  assign advance_o = byte_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = emit_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && emit_i) begin
      packet_q <= packet_i;
    end
  end

  assign out_valid_o = valid_q;
  assign packet_o    = packet_q;

endmodule

>>> hw/rtl/serial_mouse_packet_decoder_top.sv
// Serial mouse packet decoder: one received byte per transaction in, one
// packet (header, X delta, Y delta) per transaction out.
// Throughput is one byte per cycle while the packet channel does not stall. A
// packet passes through the input register and then the result register after
// the transaction of its last byte. Reset is asynchronous and active low; it
// selects Mouse Systems mode and empties both registers.
`timescale 1ns / 1ps

module serial_mouse_packet_decoder_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Mode register write port: 0 selects Mouse Systems, 1 selects Microsoft.
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  // Received byte channel.
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  // Packet channel.
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        header_o,
  output logic signed [7:0] delta_x_o,
  output logic signed [7:0] delta_y_o
);

  import smpd_pkg::*;

  // The input register holds one byte. The decoder updates the packet
  // phase and held fields as the byte moves on, and the result register
  // keeps a finished packet until the downstream side takes it, so a new
  // byte can be taken while a packet still waits. After reset the decoder
  // waits for a sync byte.
  logic       advance;
  logic       byte_valid;
  logic [7:0] byte_q;
  logic       emit;
  packet_t    packet_next;
  packet_t    packet_out;

  smpd_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .advance_i   (advance),
    .byte_valid_o(byte_valid),
    .byte_o      (byte_q)
  );

  // Sync detection, field merging and Y negation all happen here, in the
  // cycle in which the byte moves from the input register onward.
  smpd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .advance_i  (advance),
    .byte_i     (byte_q),
    .emit_o     (emit),
    .packet_o   (packet_next)
  );

  smpd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_valid),
    .emit_i      (emit),
    .packet_i    (packet_next),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .packet_o    (packet_out)
  );

  assign header_o  = packet_out.header;
  assign delta_x_o = packet_out.delta_x;
  assign delta_y_o = packet_out.delta_y;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import smpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned FLUSH_CYCLES = 4;
  localparam int unsigned SEGMENTS     = 8;
  localparam int unsigned SEGMENT_SIZE = 205;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_wdata_i = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [7:0]        rx_byte_i   = 8'h00;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        header_o;
  logic signed [7:0] delta_x_o;
  logic signed [7:0] delta_y_o;

  // Mirror of the decoder state, advanced once per accepted byte.
  protocol_mode_e cur_mode   = MODE_MOUSE_SYSTEMS;
  logic [2:0]     rx_phase   = PH_WAIT_SYNC;
  logic [7:0]     pkt_hdr    = 8'h00;
  logic [7:0]     pkt_x      = 8'h00;
  logic [7:0]     pkt_y_high = 8'h00;

  packet_t     pending_packets[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  bit          idle_on     = 1'b1;
  logic        rx_hold     = 1'b0;
  int unsigned rx_wait     = 0;

  serial_mouse_packet_decoder_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .header_o   (header_o),
    .delta_x_o  (delta_x_o),
    .delta_y_o  (delta_y_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The run must never hang: a stuck handshake ends it here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Works out the packet, if any, that one accepted byte completes.
  function automatic void decode_byte(input logic [7:0] b);
    packet_t pkt;
    if (cur_mode == MODE_MICROSOFT) begin
      case (rx_phase)
        PH_X_FIRST: begin
          pkt_x    = (pkt_x & HIGH_TWO) | (b & LOW_SIX);
          rx_phase = PH_Y_FIRST;
        end
        PH_Y_FIRST: begin
          pkt.header  = pkt_hdr;
          pkt.delta_x = pkt_x;
          pkt.delta_y = (pkt_y_high & HIGH_TWO) | (b & LOW_SIX);
          pending_packets.push_back(pkt);
          rx_phase = PH_WAIT_SYNC;
        end
        default: begin
          // Data bytes are never checked for bit 6, only bytes between packets.
          if ((b & MS_SYNC_BIT) != 8'h00) begin
            pkt_hdr    = HDR_BASE | {6'b0, b[5:4]};
            pkt_x      = {b[1:0], 6'b0};
            pkt_y_high = {b[3:2], 6'b0};
            rx_phase   = PH_X_FIRST;
          end
        end
      endcase
    end else begin
      case (rx_phase)
        PH_X_FIRST, PH_X_SECOND: begin
          pkt_x    = b;
          rx_phase = rx_phase + 3'd1;
        end
        PH_Y_FIRST, PH_Y_SECOND: begin
          // Y is negated; minus 128 wraps onto itself.
          pkt.header  = pkt_hdr;
          pkt.delta_x = pkt_x;
          pkt.delta_y = 8'd0 - b;
          pending_packets.push_back(pkt);
          rx_phase = rx_phase + 3'd1;
        end
        default: begin
          // Buttons are active low: bit 2 is left, bit 0 is right.
          if ((b & MS_SYNC_MASK) == MS_SYNC_VAL) begin
            pkt_hdr  = HDR_BASE | {6'b0, ~b[2], ~b[0]};
            rx_phase = PH_X_FIRST;
          end
        end
      endcase
    end
  endfunction

  // Offers one byte after a random gap and waits for its transaction.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_byte(b);
    bytes_sent++;
  endtask

  // Stops offering bytes and lets every packet, and any byte still in the
  // pipeline, come out before the block is touched again.
  task automatic drain(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (pending_packets.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_mode(input protocol_mode_e m);
    drain(FLUSH_CYCLES);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = m;
    rx_phase = PH_WAIT_SYNC;
  endtask

  // Sends a packet in the current protocol, cut short when data_bytes is
  // below the full count.
  task automatic send_packet(input int unsigned data_bytes);
    logic [7:0] sync;
    sync = 8'($urandom);
    if (cur_mode == MODE_MICROSOFT) sync = sync | MS_SYNC_BIT;
    else sync = MS_SYNC_VAL | (sync & ~MS_SYNC_MASK);
    send_byte(sync);
    repeat (data_bytes) send_byte(8'($urandom));
  endtask

  function automatic int unsigned full_data_bytes();
    return (cur_mode == MODE_MICROSOFT) ? 2 : 4;
  endfunction

  // Receiver pacing: after every packet transaction it holds off for a random
  // number of cycles, and it stays off as long as the long hold is active.
  always @(posedge clk_i) begin : rx_pace
    int unsigned w;
    w = rx_wait;
    if (out_valid_o && out_ready_i) w = idle_on ? $urandom_range(0, 19) : 0;
    else if (w != 0) w = w - 1;
    rx_wait     <= w;
    out_ready_i <= (w == 0) && !rx_hold;
  end

  // Every packet transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin : packet_check
    packet_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_packets.size() == 0) begin
        $display("%0t: unexpected packet %h %h %h", $time, header_o, delta_x_o,
                 delta_y_o);
        mismatches++;
      end else begin
        want = pending_packets.pop_front();
        if (header_o !== want.header) begin
          $display("%0t: header expected %h, got %h", $time, want.header, header_o);
          mismatches++;
        end
        if (delta_x_o !== want.delta_x) begin
          $display("%0t: delta_x expected %0d, got %0d", $time, want.delta_x, delta_x_o);
          mismatches++;
        end
        if (delta_y_o !== want.delta_y) begin
          $display("%0t: delta_y expected %0d, got %0d", $time, want.delta_y, delta_y_o);
          mismatches++;
        end
      end
    end
  end

  // Runs in the mode left by reset. Covers the both-pressed and right-only
  // button states, the largest deltas, negation of minus 128, a sync-looking
  // data byte and the bytes dropped before a sync and after the second pair.
  task automatic test_mouse_systems_directed();
    send_byte(8'h88);
    send_byte(8'h7f);
    send_byte(8'h80);
    send_byte(8'h7f);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h87);
    send_byte(8'h85);
    send_byte(8'h7f);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h86);
    send_byte(8'h00);
    send_byte(8'hff);
  endtask

  // Microsoft framing: noise before the first packet, all-ones and all-zeros high
  // bits, and data bytes with bits 6 and 7 set that must not resync.
  task automatic test_microsoft_directed();
    set_mode(MODE_MICROSOFT);
    send_byte(8'h3f);
    send_byte(8'h80);
    send_byte(8'h7f);
    send_byte(8'hff);
    send_byte(8'hbf);
    send_byte(8'hc0);
    send_byte(8'h40);
    send_byte(8'h00);
  endtask

  // A mode write in the middle of a packet abandons it, even when the
  // written value equals the current one.
  task automatic test_mode_switch();
    set_mode(MODE_MOUSE_SYSTEMS);
    send_byte(8'h83);
    send_byte(8'h12);
    send_byte(8'h34);
    set_mode(MODE_MICROSOFT);
    send_byte(8'h56);
    set_mode(MODE_MICROSOFT);
    send_byte(8'h15);
    send_byte(8'h2a);
  endtask

  // The receiver stops for a long stretch while full packets keep coming, so
  // both pipeline registers fill and the input channel must stall.
  task automatic test_backpressure();
    set_mode(MODE_MICROSOFT);
    idle_on = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (25) send_packet(full_data_bytes());
    drain(FLUSH_CYCLES);
    idle_on = 1'b1;
  endtask

  // Mostly well-formed packets with random content, with some noise bytes
  // and cut-off packets mixed in, across several mode settings.
  task automatic test_random_traffic();
    int unsigned seg;
    int unsigned pick;
    int unsigned stop_at;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 2) set_mode(seg[0] ? MODE_MICROSOFT : MODE_MOUSE_SYSTEMS);
      else set_mode(protocol_mode_e'($urandom_range(0, 1)));
      idle_on = ($urandom_range(0, 3) != 0);
      stop_at = bytes_sent + SEGMENT_SIZE;
      while (bytes_sent < stop_at) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) send_packet(full_data_bytes());
        else if (pick == 8) send_byte(8'($urandom));
        else send_packet($urandom_range(0, full_data_bytes() - 1));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_mouse_systems_directed();
    test_microsoft_directed();
    test_mode_switch();
    test_backpressure();
    test_random_traffic();
    drain(8);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
